### src/i2c_master_bit_sequencer_defines.svh
// Assertion macros shared by the bit sequencer RTL.
// No dependencies; include by bare file name in modules that assert.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// Check an expression at every clock edge out of reset
`define I2CBS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");
// Check that an antecedent implies a consequent in the same cycle
`define I2CBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");
`else
`define I2CBS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define I2CBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

### src/i2cbs_pkg.sv
// Types, codes and phase tables for the I2C master bit sequencer.
// No dependencies; used by i2cbs_step, i2cbs_out_skid and the top level.
package i2cbs_pkg;

    // Command codes carried by each input word
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5
    } op_t;

    // Active sequence, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_STOP  = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_READ  = 6'b010000,
        ST_ACK   = 6'b100000
    } cmd_state_t;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned PHASE_W  = 5;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd10;
    localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;

    // Phase counts per sequence
    localparam logic [PHASE_W-1:0] PHASES_START = 5'd4;
    localparam logic [PHASE_W-1:0] PHASES_STOP  = 5'd4;
    localparam logic [PHASE_W-1:0] PHASES_WRITE = 5'd19;
    localparam logic [PHASE_W-1:0] PHASES_READ  = 5'd25;
    localparam logic [PHASE_W-1:0] PHASES_ACK   = 5'd2;

    // Read sub-phase: (phase - 1) mod 3, tracked as a counter
    localparam logic [1:0] K_RELEASE = 2'd0;
    localparam logic [1:0] K_LOW     = 2'd1;
    localparam logic [1:0] K_HIGH    = 2'd2;

    typedef struct packed {
        logic scl;
        logic sda;
    } pins_t;

    // One result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0] pad;
        logic       refused;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } result_t;

    function automatic cmd_state_t op_to_state(op_t op);
        cmd_state_t st;
        unique case (op)
            OP_START: st = ST_START;
            OP_STOP:  st = ST_STOP;
            OP_WRITE: st = ST_WRITE;
            OP_READ:  st = ST_READ;
            OP_ACK:   st = ST_ACK;
            default:  st = ST_IDLE;
        endcase
        return st;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_count(cmd_state_t st);
        logic [PHASE_W-1:0] n;
        unique case (st)
            ST_START: n = PHASES_START;
            ST_STOP:  n = PHASES_STOP;
            ST_WRITE: n = PHASES_WRITE;
            ST_READ:  n = PHASES_READ;
            ST_ACK:   n = PHASES_ACK;
            default:  n = '0;
        endcase
        return n;
    endfunction

    // Pin levels for entering a phase; levels not named are kept
    function automatic pins_t apply_phase(cmd_state_t st, logic [PHASE_W-1:0] idx,
                                          logic [1:0] k, logic [7:0] sr, pins_t cur);
        pins_t p;
        p = cur;
        unique case (st)
            ST_START:
            begin
                if (idx == 5'd0)
                begin
                    p.scl = 1'b0;
                    p.sda = 1'b1;
                end
                else if (idx == 5'd1) p.scl = 1'b1;
                else if (idx == 5'd2) p.sda = 1'b0;
                else                  p.scl = 1'b0;
            end
            ST_STOP:
            begin
                if (idx == 5'd0)      p.scl = 1'b0;
                else if (idx == 5'd1) p.sda = 1'b0;
                else if (idx == 5'd2) p.scl = 1'b1;
                else                  p.sda = 1'b1;
            end
            ST_WRITE:
            begin
                if (idx < 5'd16)
                begin
                    if (!idx[0])
                    begin
                        p.scl = 1'b0;
                        p.sda = sr[3'd7 - idx[3:1]];
                    end
                    else p.scl = 1'b1;
                end
                else if (idx == 5'd16) p.scl = 1'b0;
                else if (idx == 5'd17) p.sda = 1'b1;
                else                   p.scl = 1'b1;
            end
            ST_READ:
            begin
                if (idx == 5'd0)           p.scl = 1'b0;
                else if (k == K_RELEASE)   p.sda = 1'b1;
                else if (k == K_LOW)       p.scl = 1'b0;
                else                       p.scl = 1'b1;
            end
            ST_ACK:
            begin
                if (idx == 5'd0)
                begin
                    p.scl = 1'b0;
                    p.sda = ~sr[0];
                end
                else p.scl = 1'b1;
            end
            default: p = cur;
        endcase
        return p;
    endfunction

endpackage

### src/i2cbs_step.sv
// Sequencer state and the per-tick update that yields one result word.
// Depends on i2cbs_pkg and i2c_master_bit_sequencer_defines.svh.
`include "i2c_master_bit_sequencer_defines.svh"
module i2cbs_step
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_fire,
    input  logic [2:0]                       operation,
    input  logic [7:0]                       tx_byte,
    input  logic                             send_ack,
    input  logic                             sda_in,
    input  logic [i2cbs_pkg::TICK_W-1:0]     phase_ticks,
    output i2cbs_pkg::result_t               result
);

    i2cbs_pkg::cmd_state_t              state_reg, state_next;
    logic [i2cbs_pkg::PHASE_W-1:0]      idx_reg, idx_next;
    logic [1:0]                         k_reg, k_next;
    logic [i2cbs_pkg::TICK_W-1:0]       tc_reg, tc_next;
    logic [7:0]                         sr_reg, sr_next;
    i2cbs_pkg::pins_t                   pins_reg, pins_next;
    logic [7:0]                         last_reg, last_next;
    logic [i2cbs_pkg::TICK_W-1:0]       limit;
    logic                               rx_valid;
    logic                               refused;
    i2cbs_pkg::op_t                     op;
    i2cbs_pkg::cmd_state_t              op_state;

    assign limit    = (phase_ticks == '0) ? i2cbs_pkg::TICK_W'(1) : phase_ticks;
    assign op       = i2cbs_pkg::op_t'(operation);
    assign op_state = i2cbs_pkg::op_to_state(op);

    // Advance the phase, then take a new command if the sequencer is free
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        tc_next    = tc_reg;
        sr_next    = sr_reg;
        pins_next  = pins_reg;
        last_next  = last_reg;
        rx_valid   = 1'b0;
        refused    = 1'b0;

        if (state_next != i2cbs_pkg::ST_IDLE)
        begin
            if (tc_next >= limit)
            begin
                // Sample SDA at the end of each SCL-high read phase
                if (state_next == i2cbs_pkg::ST_READ && idx_next != '0
                    && k_next == i2cbs_pkg::K_HIGH)
                    sr_next = {sr_next[6:0], sda_in};
                idx_next = idx_next + 1'b1;
                k_next   = (k_next == i2cbs_pkg::K_HIGH) ? i2cbs_pkg::K_RELEASE
                                                         : k_next + 2'd1;
                tc_next  = '0;
                if (idx_next >= i2cbs_pkg::phase_count(state_next))
                begin
                    if (state_next != i2cbs_pkg::ST_START) pins_next.scl = 1'b0;
                    if (state_next == i2cbs_pkg::ST_READ)
                    begin
                        last_next = sr_next;
                        rx_valid  = 1'b1;
                    end
                    state_next = i2cbs_pkg::ST_IDLE;
                    idx_next   = '0;
                    k_next     = i2cbs_pkg::K_HIGH;
                end
                else
                begin
                    pins_next = i2cbs_pkg::apply_phase(state_next, idx_next, k_next,
                                                       sr_next, pins_next);
                end
            end
            if (state_next != i2cbs_pkg::ST_IDLE && op != i2cbs_pkg::OP_NONE)
                refused = 1'b1;
        end

        if (state_next == i2cbs_pkg::ST_IDLE && op_state != i2cbs_pkg::ST_IDLE)
        begin
            state_next = op_state;
            idx_next   = '0;
            k_next     = i2cbs_pkg::K_HIGH;
            tc_next    = '0;
            if (op == i2cbs_pkg::OP_WRITE)    sr_next = tx_byte;
            else if (op == i2cbs_pkg::OP_ACK) sr_next = {7'd0, send_ack};
            else                              sr_next = '0;
            pins_next = i2cbs_pkg::apply_phase(op_state, '0, i2cbs_pkg::K_HIGH,
                                               sr_next, pins_next);
        end

        // Count ticks shown in the current phase, saturating
        if (state_next != i2cbs_pkg::ST_IDLE && tc_next != i2cbs_pkg::TICK_MAX)
            tc_next = tc_next + 1'b1;
    end

    // Pack the result word
    always_comb
    begin
        result          = '0;
        result.scl_out  = pins_next.scl;
        result.sda_out  = pins_next.sda;
        result.busy_res = (state_next != i2cbs_pkg::ST_IDLE);
        result.rx_byte  = last_next;
        result.rx_valid = rx_valid;
        result.refused  = refused;
    end

    // Hold state between ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= i2cbs_pkg::ST_IDLE;
            idx_reg      <= '0;
            k_reg        <= i2cbs_pkg::K_HIGH;
            tc_reg       <= '0;
            sr_reg       <= '0;
            pins_reg.scl <= 1'b0;
            pins_reg.sda <= 1'b1;
            last_reg     <= '0;
        end
        else if (tick_fire)
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            tc_reg    <= tc_next;
            sr_reg    <= sr_next;
            pins_reg  <= pins_next;
            last_reg  <= last_next;
        end
    end

    `I2CBS_ASSERT_ALWAYS(a_state_onehot, clk, rst_n, $onehot(state_reg))
    `I2CBS_ASSERT_IMPLY(a_busy_counts, clk, rst_n, state_reg != i2cbs_pkg::ST_IDLE, tc_reg != '0)
    `I2CBS_ASSERT_IMPLY(a_idle_phase, clk, rst_n, state_reg == i2cbs_pkg::ST_IDLE, idx_reg == '0 && k_reg == i2cbs_pkg::K_HIGH)

endmodule

### src/i2cbs_out_skid.sv
// Two-entry output buffer for result words: output register plus skid stage.
// Depends on i2cbs_pkg and i2c_master_bit_sequencer_defines.svh.
`include "i2c_master_bit_sequencer_defines.svh"
module i2cbs_out_skid
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cbs_pkg::result_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cbs_pkg::result_t  out_data
);

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    i2cbs_pkg::result_t out_data_reg, out_data_next;
    i2cbs_pkg::result_t skid_data_reg, skid_data_next;
    logic               in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Refill the output from the skid stage first, else from the input
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = in_data;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `I2CBS_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `I2CBS_ASSERT_IMPLY(a_skid_only_stalled, clk, rst_n, $rose(skid_valid_reg), $past(out_valid_reg && !out_ready))
    `I2CBS_ASSERT_IMPLY(a_out_held, clk, rst_n, $past(out_valid_reg && !out_ready), out_valid_reg)

endmodule

### src/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: config register, step logic, output buffer.
// Depends on i2cbs_pkg, i2cbs_step and i2cbs_out_skid.
//
// Usage: every input word is one bus tick. s_tuser carries the command
// (none, start, stop, write byte, read byte, master ack); s_tdata carries the
// byte to write, the ack level and the sampled SDA level. Each input word
// yields exactly one result word on m_* with the SCL/SDA levels to drive,
// busy, the last read byte, a read-done pulse and a refused flag.
// phase_ticks (cfg_we/cfg_wdata) sets how many ticks each pin phase lasts;
// zero acts as one. Write it only while the sequencer is idle.
// Throughput: one word per cycle while s_tready is high; the update of the sequencer state is a
// single pass of logic between the state registers and the output register.
// Output: each result is registered in the output buffer before it appears on m_*.
// Receiver stall: a two-entry output buffer keeps taking one more word while
// a result waits; s_tready drops only when both entries are full.
// Reset: sequencer idle, SCL low, SDA released, read byte zero,
// phase_ticks 10, output buffer empty.
module i2c_master_bit_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: phase_ticks
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
    input  logic [2:0]  s_tuser,   // [2:0] operation
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] scl_out, [1] sda_out, [2] busy_res,
                                   // [10:3] rx_byte, [11] rx_valid, [12] refused,
                                   // [15:13] zero
);

    logic [i2cbs_pkg::TICK_W-1:0] phase_ticks_reg;
    logic                         tick_fire;
    i2cbs_pkg::result_t           step_result;
    i2cbs_pkg::result_t           out_result;

    assign tick_fire = s_tvalid && s_tready;

    // Hold the phase length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_ticks_reg <= i2cbs_pkg::PHASE_TICKS_RESET;
        else if (cfg_we)
            phase_ticks_reg <= cfg_wdata;
    end

    i2cbs_step u_step
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_fire   (tick_fire),
        .operation   (s_tuser),
        .tx_byte     (s_tdata[7:0]),
        .send_ack    (s_tdata[8]),
        .sda_in      (s_tdata[9]),
        .phase_ticks (phase_ticks_reg),
        .result      (step_result)
    );

    i2cbs_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = out_result;

endmodule

### tb/sv/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for i2c_master_bit_sequencer: a local predictor of the pin sequencer
// and phase timer scores every result word against the stream driven in.
// Depends on i2cbs_pkg (command codes, result layout) and the top level of the block.
module i2c_master_bit_sequencer_tb;

    // One bus tick as offered on the input stream
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] txb;
        logic       ack;
        logic       sda;
    } tick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
    logic [2:0]  s_tuser = '0;   // [2:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [0] scl_out, [1] sda_out, [2] busy_res, [10:3] rx_byte,
                                 // [11] rx_valid, [12] refused, [15:13] zero

    // Stimulus and scoreboard
    tick_t                tick_queue[$];
    i2cbs_pkg::result_t   result_due[$];
    int                   err_count = 0;
    int                   ticks_made = 0;
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;
    logic                 hold_start = 1'b0;
    int                   hold_left = 0;

    // Predictor state
    logic [15:0]          phase_len = i2cbs_pkg::PHASE_TICKS_RESET;
    i2cbs_pkg::op_t       seq_cmd = i2cbs_pkg::OP_NONE;
    int                   seq_phase = 0;
    int                   seq_ticks = 0;
    logic [7:0]           seq_shift = '0;
    logic                 pin_scl = 1'b0;
    logic                 pin_sda = 1'b1;
    logic [7:0]           rx_last = '0;

    i2c_master_bit_sequencer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Number of pin phases in each command sequence
    function automatic int phase_total(input logic [2:0] c);
        case (c)
            i2cbs_pkg::OP_START, i2cbs_pkg::OP_STOP: return 4;
            i2cbs_pkg::OP_WRITE:                     return 19;
            i2cbs_pkg::OP_READ:                      return 25;
            i2cbs_pkg::OP_ACK:                       return 2;
            default:                                 return 0;
        endcase
    endfunction

    // Ticks per phase; zero counts as one
    function automatic int tick_limit();
        return (phase_len == 16'd0) ? 1 : int'(phase_len);
    endfunction

    // Set the pin levels for the phase just entered; untouched levels are kept
    function automatic void enter_phase();
        case (seq_cmd)
            i2cbs_pkg::OP_START:
            begin
                case (seq_phase)
                    0:
                    begin
                        pin_scl = 1'b0;
                        pin_sda = 1'b1;
                    end
                    1:       pin_scl = 1'b1;
                    2:       pin_sda = 1'b0;
                    default: pin_scl = 1'b0;
                endcase
            end
            i2cbs_pkg::OP_STOP:
            begin
                case (seq_phase)
                    0:       pin_scl = 1'b0;
                    1:       pin_sda = 1'b0;
                    2:       pin_scl = 1'b1;
                    default: pin_sda = 1'b1;
                endcase
            end
            i2cbs_pkg::OP_WRITE:
            begin
                if (seq_phase < 16)
                begin
                    if (seq_phase % 2 == 0)
                    begin
                        pin_scl = 1'b0;
                        pin_sda = seq_shift[7 - seq_phase / 2];
                    end
                    else
                        pin_scl = 1'b1;
                end
                else if (seq_phase == 16)
                    pin_scl = 1'b0;
                else if (seq_phase == 17)
                    pin_sda = 1'b1;
                else
                    pin_scl = 1'b1;
            end
            i2cbs_pkg::OP_READ:
            begin
                if (seq_phase == 0)
                    pin_scl = 1'b0;
                else
                begin
                    case ((seq_phase - 1) % 3)
                        0:       pin_sda = 1'b1;
                        1:       pin_scl = 1'b0;
                        default: pin_scl = 1'b1;
                    endcase
                end
            end
            i2cbs_pkg::OP_ACK:
            begin
                if (seq_phase == 0)
                begin
                    pin_scl = 1'b0;
                    pin_sda = ~seq_shift[0];
                end
                else
                    pin_scl = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Advance the sequencer by one tick and return the result word it shows
    function automatic i2cbs_pkg::result_t bus_tick(input tick_t t);
        i2cbs_pkg::result_t r;
        int                 limit;
        logic               refused;
        logic               rx_done;
        limit   = tick_limit();
        refused = 1'b0;
        rx_done = 1'b0;
        // Close the current phase once it has been shown long enough
        if (seq_cmd != i2cbs_pkg::OP_NONE)
        begin
            if (seq_ticks >= limit)
            begin
                if (seq_cmd == i2cbs_pkg::OP_READ && seq_phase >= 1
                    && (seq_phase - 1) % 3 == 2)
                    seq_shift = {seq_shift[6:0], t.sda};
                seq_phase++;
                seq_ticks = 0;
                if (seq_phase >= phase_total(seq_cmd))
                begin
                    if (seq_cmd != i2cbs_pkg::OP_START)
                        pin_scl = 1'b0;
                    if (seq_cmd == i2cbs_pkg::OP_READ)
                    begin
                        rx_last = seq_shift;
                        rx_done = 1'b1;
                    end
                    seq_cmd   = i2cbs_pkg::OP_NONE;
                    seq_phase = 0;
                end
                else
                    enter_phase();
            end
            if (seq_cmd != i2cbs_pkg::OP_NONE && t.op != i2cbs_pkg::OP_NONE)
                refused = 1'b1;
        end
        // Take a new command when idle, including on the finishing tick
        if (seq_cmd == i2cbs_pkg::OP_NONE && t.op >= i2cbs_pkg::OP_START
            && t.op <= i2cbs_pkg::OP_ACK)
        begin
            seq_cmd   = i2cbs_pkg::op_t'(t.op);
            seq_phase = 0;
            seq_ticks = 0;
            if (t.op == i2cbs_pkg::OP_WRITE)
                seq_shift = t.txb;
            else if (t.op == i2cbs_pkg::OP_ACK)
                seq_shift = {7'd0, t.ack};
            else
                seq_shift = '0;
            enter_phase();
        end
        if (seq_cmd != i2cbs_pkg::OP_NONE && seq_ticks < 'hFFFF)
            seq_ticks++;
        r          = '0;
        r.scl_out  = pin_scl;
        r.sda_out  = pin_sda;
        r.busy_res = (seq_cmd != i2cbs_pkg::OP_NONE);
        r.rx_byte  = rx_last;
        r.rx_valid = rx_done;
        r.refused  = refused;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic add_tick(input logic [2:0] op, input logic [7:0] txb,
                            input logic ack, input logic sda);
        tick_t t;
        t.op  = op;
        t.txb = txb;
        t.ack = ack;
        t.sda = sda;
        tick_queue.push_back(t);
        ticks_made++;
    endtask

    // Queue a command and the ticks that fill its sequence; slack shifts the next command
    // later (idle ticks) or earlier (refused), noise puts stray commands into busy ticks
    task automatic add_cmd(input logic [2:0] op, input logic [7:0] txb, input logic ack,
                           input int sda_mode, input int slack, input int noise);
        int   busy_fill;
        int   count;
        logic [2:0] fop;
        logic sda;
        busy_fill = phase_total(op) * tick_limit() - 1;
        if (busy_fill < 0)
            busy_fill = 0;
        count = busy_fill + slack;
        sda = (sda_mode == 2) ? 1'($urandom_range(1)) : 1'(sda_mode);
        add_tick(op, txb, ack, sda);
        for (int i = 0; i < count; i++)
        begin
            fop = i2cbs_pkg::OP_NONE;
            if ($urandom_range(99) < noise)
                fop = (i < busy_fill) ? 3'($urandom_range(1, 7)) : 3'($urandom_range(6, 7));
            sda = (sda_mode == 2) ? 1'($urandom_range(1)) : 1'(sda_mode);
            add_tick(fop, 8'($urandom), 1'($urandom_range(1)), sda);
        end
    endtask

    function automatic int rand_slack();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return -int'($urandom_range(1, 3));
    endfunction

    // One bus transfer: start, address write, a few data bytes, stop; sometimes a stray command
    task automatic add_transfer();
        int n;
        if ($urandom_range(99) < 15)
            add_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)), 2,
                    rand_slack(), 30);
        else
        begin
            add_cmd(i2cbs_pkg::OP_START, 8'($urandom), 1'($urandom_range(1)), 2,
                    rand_slack(), 3);
            add_cmd(i2cbs_pkg::OP_WRITE, 8'($urandom), 1'($urandom_range(1)), 2,
                    rand_slack(), 3);
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                if ($urandom_range(1))
                    add_cmd(i2cbs_pkg::OP_WRITE, 8'($urandom), 1'($urandom_range(1)), 2,
                            rand_slack(), 3);
                else
                begin
                    add_cmd(i2cbs_pkg::OP_READ, 8'($urandom), 1'($urandom_range(1)), 2,
                            rand_slack(), 3);
                    add_cmd(i2cbs_pkg::OP_ACK, 8'($urandom), 1'($urandom_range(1)), 2,
                            rand_slack(), 3);
                end
            end
            add_cmd(i2cbs_pkg::OP_STOP, 8'($urandom), 1'($urandom_range(1)), 2,
                    rand_slack(), 3);
        end
    endtask

    // Hold the sender until every result is in and the sequencer has gone idle
    task automatic settle();
        int rem;
        do
        begin
            while (tick_queue.size() != 0 || result_due.size() != 0 || s_tvalid)
                @(negedge clk);
            if (seq_cmd != i2cbs_pkg::OP_NONE)
            begin
                rem = (phase_total(seq_cmd) - seq_phase) * tick_limit() - seq_ticks + 1;
                if (rem < 1)
                    rem = 1;
                repeat (rem)
                    add_tick(i2cbs_pkg::OP_NONE, 8'($urandom), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            end
        end
        while (seq_cmd != i2cbs_pkg::OP_NONE || tick_queue.size() != 0);
    endtask

    task automatic set_phase_len(input logic [15:0] v);
        settle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        phase_len = v;
        @(negedge clk);
    endtask

    task automatic random_phase(input int budget, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        ticks_made    = 0;
        while (ticks_made < budget)
            add_transfer();
    endtask

    // Driver: offer queued ticks, predict each word as it is accepted
    always @(posedge clk)
    begin
        tick_t cur;
        tick_t nxt;
        logic  offer;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                cur.op  = s_tuser;
                cur.txb = s_tdata[7:0];
                cur.ack = s_tdata[8];
                cur.sda = s_tdata[9];
                result_due.push_back(bus_tick(cur));
            end
            if (!s_tvalid || s_tready)
            begin
                offer = (tick_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
                if (offer)
                begin
                    nxt = tick_queue.pop_front();
                    s_tuser <= nxt.op;
                    s_tdata <= {6'd0, nxt.sda, nxt.ack, nxt.txb};
                end
                s_tvalid <= offer;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= 400;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: score each accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        i2cbs_pkg::result_t got;
        i2cbs_pkg::result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (result_due.size() == 0)
                begin
                    $display("%0t: result word expected none actual %h", $time, m_tdata);
                    err_count++;
                end
                else
                begin
                    want = result_due.pop_front();
                    check_field("scl_out", want.scl_out, got.scl_out);
                    check_field("sda_out", want.sda_out, got.sda_out);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                    check_field("rx_valid", want.rx_valid, got.rx_valid);
                    check_field("refused", want.refused, got.refused);
                    check_field("pad", want.pad, got.pad);
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset phase length
        add_cmd(i2cbs_pkg::OP_START, 8'h00, 1'b0, 2, 0, 0);
        add_cmd(i2cbs_pkg::OP_STOP, 8'h00, 1'b0, 2, 1, 0);
        // Undefined operations while idle are ignored
        add_tick(3'd6, 8'hFF, 1'b1, 1'b1);
        add_tick(3'd7, 8'h00, 1'b0, 1'b0);

        // Directed byte transfers at the shortest phase length
        set_phase_len(16'd1);
        add_cmd(i2cbs_pkg::OP_START, 8'h00, 1'b0, 2, 0, 0);
        add_cmd(i2cbs_pkg::OP_WRITE, 8'h00, 1'b0, 0, 0, 0);
        add_cmd(i2cbs_pkg::OP_WRITE, 8'hFF, 1'b1, 1, 0, 0);
        add_cmd(i2cbs_pkg::OP_WRITE, 8'hA5, 1'b0, 2, 0, 0);
        add_cmd(i2cbs_pkg::OP_READ, 8'hFF, 1'b1, 0, 0, 0);
        add_cmd(i2cbs_pkg::OP_ACK, 8'h00, 1'b1, 2, 0, 0);
        add_cmd(i2cbs_pkg::OP_READ, 8'h00, 1'b0, 1, 0, 0);
        add_cmd(i2cbs_pkg::OP_ACK, 8'hFF, 1'b0, 2, 0, 0);
        add_cmd(i2cbs_pkg::OP_READ, 8'h5A, 1'b1, 2, 2, 0);
        add_cmd(i2cbs_pkg::OP_STOP, 8'h00, 1'b0, 2, 1, 0);
        // Commands while busy are refused: one early command, then stray ones
        add_cmd(i2cbs_pkg::OP_START, 8'h00, 1'b0, 2, -5, 0);
        add_cmd(i2cbs_pkg::OP_STOP, 8'h00, 1'b0, 2, 0, 0);
        add_cmd(i2cbs_pkg::OP_START, 8'h00, 1'b0, 2, 0, 50);
        add_cmd(i2cbs_pkg::OP_STOP, 8'h00, 1'b0, 2, 0, 50);

        // Random transfers over the idling phases and phase lengths
        random_phase(30, 0, 0);
        settle();

        // Receiver holds off while the sender keeps offering
        random_phase(30, 0, 0);
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        @(negedge clk);

        set_phase_len(16'd0);
        random_phase(50, 63, 0);
        set_phase_len(16'd2);
        random_phase(40, 0, 63);
        set_phase_len(16'd3);
        random_phase(40, 17, 17);

        set_phase_len(16'd1);
        random_phase(30, 17, 17);
        settle();

        repeat (8) @(posedge clk);
        if (err_count == 0 && result_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/i2cbs_pkg.sv
src/i2cbs_step.sv
src/i2cbs_out_skid.sv
src/i2c_master_bit_sequencer.sv
tb/sv/i2c_master_bit_sequencer_tb.sv
